>>> rtl/ktts_pkg.sv
// ----------------------------------------------------------------------------
// ktts_pkg
// shared types and constants of the keypoint threshold and top-k selector
// ----------------------------------------------------------------------------
package ktts_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int MAX_DIM_DEF  = 2048;

   // width used for size, border and limit arithmetic
   localparam int AW = 14;

   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_PUSH     = 2'd1;
   localparam logic [1:0] FUNC_FETCH    = 2'd2;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
   localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
   localparam logic [2:0] REG_THRESHOLD  = 3'd2;
   localparam logic [2:0] REG_BORDER     = 3'd3;
   localparam logic [2:0] REG_KEEP_LIMIT = 3'd4;
   localparam logic [2:0] REG_LIMIT_EN   = 3'd5;

   typedef struct packed {
      logic [11:0] map_width;
      logic [11:0] map_height;
      logic [15:0] score_threshold;
      logic [9:0]  border_margin;
      logic [10:0] keep_limit;
      logic        limit_enable;
   } cfg_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic rsp_free;
   } sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/ktts_ctrl.sv
// ----------------------------------------------------------------------------
// ktts_ctrl
// sequencer: take an item, decode it, and where needed scan the entry store and finish
// ----------------------------------------------------------------------------
module ktts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ktts_pkg::sts_type sts,
   output ktts_pkg::cmd_type cmd
);
   import ktts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = sts.need_scan ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.latch  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.decode = (state_ff == ST_DECODE);
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_FINISH) && sts.rsp_free;
   end

endmodule

>>> rtl/ktts_dp.sv
// ----------------------------------------------------------------------------
// ktts_dp
// datapath: raster position, survivor test, entry store, scan and result
// ----------------------------------------------------------------------------
module ktts_dp #(
   parameter int CAPACITY = ktts_pkg::CAPACITY_DEF,
   parameter int MAX_DIM  = ktts_pkg::MAX_DIM_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ktts_pkg::cfg_type cfg,
   input  ktts_pkg::cmd_type cmd,
   output ktts_pkg::sts_type sts,
   input  logic [1:0]        req_func,
   input  logic [15:0]       req_score,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [10:0]       rsp_x,
   output logic [10:0]       rsp_y,
   output logic [15:0]       rsp_pscore,
   output logic              rsp_pvalid,
   output logic              rsp_plast,
   output logic              rsp_ovf
);
   import ktts_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RW    = $clog2(MAX_DIM + 1);
   localparam int PW    = $clog2(MAX_DIM);
   localparam int WW    = 1 + 2 * PW + 16;

   logic [1:0]       func_ff;
   logic [15:0]      score_ff;
   logic [RW-1:0]    row_ff, col_ff;
   logic [2*PW-1:0]  pos_ff;
   logic [CNT_W-1:0] count_ff;
   logic [22:0]      total_ff;
   logic             ovf_ff;

   // scan state
   logic [CNT_W-1:0] issue_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [WW-1:0]    rd_data_ff;
   logic             found_ff;
   logic [1:0]       open_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [15:0]      best_score_ff;
   logic [2*PW-1:0]  best_pos_ff;

   logic [WW-1:0] mem [CAPACITY];
   logic          we;
   logic [IDX_W-1:0] waddr;
   logic [WW-1:0] wdata;

   logic            rsp_valid_ff;
   logic [10:0]     rsp_x_ff, rsp_y_ff;
   logic [15:0]     rsp_score_ff;
   logic            rsp_pvalid_ff, rsp_last_ff, rsp_ovf_ff;

   logic [AW-1:0] w, h, b, r, c, k;
   logic          in_frame, survive, sorted, issuing;
   logic          is_push, is_fetch;
   logic [2*PW-1:0] rd_pos;
   logic [15:0]     rd_score;
   logic            rd_emit, take;

   always_comb begin
      w = (cfg.map_width == '0) ? AW'(1) :
          ((AW'(cfg.map_width) > AW'(MAX_DIM)) ? AW'(MAX_DIM) : AW'(cfg.map_width));
      h = (cfg.map_height == '0) ? AW'(1) :
          ((AW'(cfg.map_height) > AW'(MAX_DIM)) ? AW'(MAX_DIM) : AW'(cfg.map_height));
      b = AW'(cfg.border_margin);
      r = AW'(row_ff);
      c = AW'(col_ff);
      k = (AW'(cfg.keep_limit) > AW'(CAPACITY)) ? AW'(CAPACITY) : AW'(cfg.keep_limit);
      is_push  = (func_ff == FUNC_PUSH);
      is_fetch = (func_ff == FUNC_FETCH);
      in_frame = r < h;
      survive  = is_push && in_frame && (score_ff > cfg.score_threshold) &&
                 (r >= b) && (r + b < h) && (c >= b) && (c + b < w);
      sorted   = cfg.limit_enable && (total_ff > 23'(k));
      issuing  = AW'(issue_ff) < AW'(count_ff);
      sts.need_scan = is_fetch || (survive && cfg.limit_enable &&
                      (AW'(count_ff) >= k) && (k != '0) && (count_ff != '0));
      sts.scan_done = !issuing && !rd_valid_ff;
      // only a fetch has to wait for the output register
      sts.rsp_free  = !rsp_valid_ff || rsp_tready || !is_fetch;
   end

   // compare stage on the registered read data
   always_comb begin
      rd_emit  = rd_data_ff[WW-1];
      rd_pos   = rd_data_ff[WW-2:16];
      rd_score = rd_data_ff[15:0];
      take     = 1'b0;
      if (is_fetch) begin
         if (!rd_emit) begin
            if (!found_ff) take = 1'b1;
            else if (sorted)
               take = (rd_score > best_score_ff) ||
                      (rd_score == best_score_ff && rd_pos < best_pos_ff);
            else
               take = rd_pos < best_pos_ff;
         end
      end else begin
         take = !found_ff || (rd_score < best_score_ff) ||
                (rd_score == best_score_ff && best_pos_ff < rd_pos);
      end
   end

   // entry store write port
   always_comb begin
      we    = 1'b0;
      waddr = count_ff[IDX_W-1:0];
      wdata = {1'b0, row_ff[PW-1:0], col_ff[PW-1:0], score_ff};
      if (cmd.decode && survive && !sts.need_scan) begin
         if (cfg.limit_enable) we = AW'(count_ff) < k;
         else                  we = count_ff < CNT_W'(CAPACITY);
      end else if (cmd.finish && found_ff) begin
         waddr = best_idx_ff;
         if (is_fetch) begin
            we    = 1'b1;
            wdata = {1'b1, best_pos_ff, best_score_ff};
         end else begin
            // raster position was already advanced at decode
            we    = score_ff > best_score_ff;
            wdata = {1'b0, pos_ff, score_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         score_ff <= req_score;
      end
      if (cmd.decode) pos_ff <= {row_ff[PW-1:0], col_ff[PW-1:0]};
      if (cmd.decode) issue_ff <= '0;
      else if (cmd.scan && issuing) issue_ff <= issue_ff + 1'b1;
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      if (cmd.decode) begin
         found_ff <= 1'b0;
         open_ff  <= '0;
      end else if (rd_valid_ff) begin
         if (is_fetch && !rd_emit && open_ff != 2'd2) open_ff <= open_ff + 1'b1;
         if (take) begin
            found_ff      <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_score_ff <= rd_score;
            best_pos_ff   <= rd_pos;
         end
      end
      if (cmd.finish && is_fetch) begin
         rsp_x_ff      <= found_ff ? 11'(best_pos_ff[PW-1:0]) : '0;
         rsp_y_ff      <= found_ff ? 11'(best_pos_ff[2*PW-1:PW]) : '0;
         rsp_score_ff  <= found_ff ? best_score_ff : '0;
         rsp_pvalid_ff <= found_ff;
         rsp_last_ff   <= found_ff && (open_ff < 2'd2);
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan && issuing;
         if (cmd.finish && is_fetch) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)        rsp_valid_ff <= 1'b0;
         if (cmd.decode) begin
            if (func_ff == FUNC_CLEAR) begin
               row_ff   <= '0;
               col_ff   <= '0;
               count_ff <= '0;
               total_ff <= '0;
               ovf_ff   <= 1'b0;
            end else if (is_push && in_frame) begin
               if (c + 1'b1 >= w) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
               if (survive) begin
                  if (total_ff != '1) total_ff <= total_ff + 1'b1;
                  if (we && !sts.need_scan) count_ff <= count_ff + 1'b1;
                  if (!cfg.limit_enable && count_ff >= CNT_W'(CAPACITY)) ovf_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_x      = rsp_x_ff;
   assign rsp_y      = rsp_y_ff;
   assign rsp_pscore = rsp_score_ff;
   assign rsp_pvalid = rsp_pvalid_ff;
   assign rsp_plast  = rsp_last_ff;
   assign rsp_ovf    = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.scan)) else $error("read data without scan");
   a_fetch_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && is_fetch) |=> rsp_valid_ff) else $error("fetch gave no item");

endmodule

>>> rtl/keypoint_threshold_topk_select.sv
// ----------------------------------------------------------------------------
// keypoint_threshold_topk_select
// thresholds a raster score map and keeps the best keypoints for fetching
// ----------------------------------------------------------------------------
// A clear or a pushed score that fails the test or is appended passes through
// decode only. A push that must replace the worst kept entry and every fetch scan
// the entry store through its single read port. The result of a fetch sits in an
// output register; the next fetch finishes only once it has been taken.
module keypoint_threshold_topk_select #(
   parameter int CAPACITY = ktts_pkg::CAPACITY_DEF,
   parameter int MAX_DIM  = ktts_pkg::MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // score
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // point_x, point_y, point_score, zero pad
   output logic [1:0]  rsp_tuser,  // point_valid, overflowed
   output logic        rsp_tlast,  // point_last
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import ktts_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic [10:0] px, py;
   logic [15:0] ps;
   logic        pv, po;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width       <= 12'd640;
         cfg_ff.map_height      <= 12'd480;
         cfg_ff.score_threshold <= 16'd328;
         cfg_ff.border_margin   <= 10'd4;
         cfg_ff.keep_limit      <= 11'd1024;
         cfg_ff.limit_enable    <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  cfg_ff.map_width       <= csr_wdata[11:0];
            REG_MAP_HEIGHT: cfg_ff.map_height      <= csr_wdata[11:0];
            REG_THRESHOLD:  cfg_ff.score_threshold <= csr_wdata;
            REG_BORDER:     cfg_ff.border_margin   <= csr_wdata[9:0];
            REG_KEEP_LIMIT: cfg_ff.keep_limit      <= csr_wdata[10:0];
            REG_LIMIT_EN:   cfg_ff.limit_enable    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ktts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ktts_dp #(
      .CAPACITY (CAPACITY),
      .MAX_DIM  (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_tuser),
      .req_score  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_x      (px),
      .rsp_y      (py),
      .rsp_pscore (ps),
      .rsp_pvalid (pv),
      .rsp_plast  (rsp_tlast),
      .rsp_ovf    (po)
   );

   assign rsp_tdata = {2'b00, ps, py, px};
   assign rsp_tuser = {po, pv};

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks keypoint_threshold_topk_select against a cycle-free predictor: score
// frames are pushed under many map sizes, thresholds, borders and limits, and
// every fetched point is compared field by field with the predicted point
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ktts_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int DIM_LIMIT   = 2048;
   localparam int TOTAL_SAT   = 23'h7FFFFF;
   localparam int SCAN_WAIT   = STORE_DEPTH + 64;

   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
      logic [15:0] score;
      logic        valid;
      logic        last;
      logic        ovf;
   } point_type;

   // keypoint store model, one expected point per fetch
   class keypoint_board_type;
      int unsigned map_w, map_h, thresh, border, keep_lim, lim_en;
      int unsigned kp_score[STORE_DEPTH];
      int unsigned kp_col[STORE_DEPTH];
      int unsigned kp_row[STORE_DEPTH];
      bit          kp_done[STORE_DEPTH];
      int unsigned kept, survivors, row_pos, col_pos;
      bit          ovf_flag;
      point_type   point_q[$];
      int          errors;

      function new();
         map_w = 640; map_h = 480; thresh = 328; border = 4;
         keep_lim = 1024; lim_en = 1; errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (kp_done[i]) kp_done[i] = 0;
         kept = 0; survivors = 0; row_pos = 0; col_pos = 0; ovf_flag = 0;
      endfunction

      function void write_reg(logic [2:0] idx, int unsigned v);
         case (idx)
            REG_MAP_WIDTH:  map_w = v & 12'hFFF;
            REG_MAP_HEIGHT: map_h = v & 12'hFFF;
            REG_THRESHOLD:  thresh = v & 16'hFFFF;
            REG_BORDER:     border = v & 10'h3FF;
            REG_KEEP_LIMIT: keep_lim = v & 11'h7FF;
            REG_LIMIT_EN:   lim_en = v & 1;
            default: ;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v);
         if (v == 0) return 1;
         return (v > DIM_LIMIT) ? DIM_LIMIT : v;
      endfunction

      function int unsigned limit_now();
         return (keep_lim > STORE_DEPTH) ? STORE_DEPTH : keep_lim;
      endfunction

      function bit raster_before(int unsigned a, int unsigned b);
         if (kp_row[a] != kp_row[b]) return kp_row[a] < kp_row[b];
         return kp_col[a] < kp_col[b];
      endfunction

      function void store(int unsigned i, int unsigned s, int unsigned r, int unsigned c);
         kp_score[i] = s; kp_row[i] = r; kp_col[i] = c; kp_done[i] = 0;
      endfunction

      function void push_score(int unsigned s);
         int unsigned w, h, r, c, k, worst;
         w = clamp_dim(map_w);
         h = clamp_dim(map_h);
         r = row_pos;
         c = col_pos;
         if (r >= h) return;
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
         end
         if (s <= thresh) return;
         if (r < border || r + border >= h || c < border || c + border >= w) return;
         if (survivors < TOTAL_SAT) survivors++;
         if (lim_en) begin
            k = limit_now();
            if (kept < k) begin
               store(kept, s, r, c);
               kept++;
            end else if (k > 0 && kept > 0) begin
               worst = 0;
               for (int i = 1; i < kept; i++)
                  if (kp_score[i] < kp_score[worst] ||
                      (kp_score[i] == kp_score[worst] && raster_before(worst, i)))
                     worst = i;
               if (s > kp_score[worst]) store(worst, s, r, c);
            end
         end else if (kept < STORE_DEPTH) begin
            store(kept, s, r, c);
            kept++;
         end else begin
            ovf_flag = 1;
         end
      endfunction

      function point_type fetch_point();
         point_type p;
         bit by_score, found, more;
         int unsigned best;
         by_score = lim_en && survivors > limit_now();
         found = 0; more = 0; best = 0;
         for (int i = 0; i < kept; i++) begin
            if (kp_done[i]) continue;
            if (!found) begin
               best = i;
               found = 1;
            end else if (by_score) begin
               if (kp_score[i] > kp_score[best] ||
                   (kp_score[i] == kp_score[best] && raster_before(i, best)))
                  best = i;
            end else if (raster_before(i, best)) begin
               best = i;
            end
         end
         p = '0;
         p.ovf = ovf_flag;
         if (!found) return p;
         kp_done[best] = 1;
         for (int i = 0; i < kept; i++)
            if (!kp_done[i]) more = 1;
         p.x = 11'(kp_col[best]);
         p.y = 11'(kp_row[best]);
         p.score = 16'(kp_score[best]);
         p.valid = 1;
         p.last = !more;
         return p;
      endfunction

      function void note_item(logic [1:0] func, logic [15:0] s);
         if (func == FUNC_CLEAR) clear_frame();
         else if (func == FUNC_PUSH) push_score(s);
         else if (func == FUNC_FETCH) point_q.push_back(fetch_point());
      endfunction

      function void check_point(logic [39:0] d, logic [1:0] u, logic last);
         point_type e;
         if (point_q.size() == 0) begin
            $error("unexpected point: tdata %h tuser %b", d, u);
            errors++;
            return;
         end
         e = point_q.pop_front();
         if (d[10:0] !== e.x) begin
            $error("point_x expected %0d actual %0d", e.x, d[10:0]); errors++;
         end
         if (d[21:11] !== e.y) begin
            $error("point_y expected %0d actual %0d", e.y, d[21:11]); errors++;
         end
         if (d[37:22] !== e.score) begin
            $error("point_score expected %0d actual %0d", e.score, d[37:22]); errors++;
         end
         if (u[0] !== e.valid) begin
            $error("point_valid expected %0d actual %0d", e.valid, u[0]); errors++;
         end
         if (last !== e.last) begin
            $error("point_last expected %0d actual %0d", e.last, last); errors++;
         end
         if (u[1] !== e.ovf) begin
            $error("overflowed expected %0d actual %0d", e.ovf, u[1]); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_score = '0;
   logic [1:0]  req_func = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [39:0] rsp_data;
   logic [1:0]  rsp_user;
   logic        rsp_last;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int          items_sent = 0;
   keypoint_board_type board = new();

   always #1 clock = ~clock;

   keypoint_threshold_topk_select u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_valid),
      .req_tready(req_ready),
      .req_tdata(req_score),   // score
      .req_tuser(req_func),    // func
      .rsp_tvalid(rsp_valid),
      .rsp_tready(rsp_ready),
      .rsp_tdata(rsp_data),    // point_x, point_y, point_score, zero pad
      .rsp_tuser(rsp_user),    // point_valid, overflowed
      .rsp_tlast(rsp_last),    // point_last
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_point(rsp_data, rsp_user, rsp_last);
         if (req_valid && req_ready) board.note_item(req_func, req_score);
      end
   end

   task automatic set_mode(int m);
      case (m % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 59; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 59; end
         default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
   endtask

   task automatic send_item(logic [1:0] func, logic [15:0] s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_score <= s;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // drop valid and let pending work drain before touching registers
   task automatic settle();
      @(negedge clock);
      req_valid <= 0;
      wait (board.point_q.size() == 0);
      repeat (SCAN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, int unsigned v);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= 16'(v);
      board.write_reg(idx, v);
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [15:0] pick_score(int unsigned thr);
      case ($urandom_range(5))
         0: return 16'($urandom());
         1: return 16'(thr);
         2: return (thr < 65535) ? 16'(thr + 1) : 16'(thr);
         3: return 16'($urandom_range(thr, (thr + 64 > 65535) ? 65535 : thr + 64));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_frame(int n);
      int unsigned w, h, thr, pushes, fetches;
      settle();
      set_mode(n);
      case ($urandom_range(9))
         0: w = 0;
         1: w = 4095;
         2: w = DIM_LIMIT;
         default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
         0: h = 0;
         1: h = 4095;
         default: h = $urandom_range(1, 12);
      endcase
      case ($urandom_range(7))
         0: thr = 0;
         1: thr = 65535;
         default: thr = $urandom_range(65535);
      endcase
      write_csr(REG_MAP_WIDTH, w);
      write_csr(REG_MAP_HEIGHT, h);
      write_csr(REG_THRESHOLD, thr);
      write_csr(REG_BORDER, ($urandom_range(15) == 0) ? 1023 : $urandom_range(3));
      case ($urandom_range(7))
         0: write_csr(REG_KEEP_LIMIT, 0);
         1: write_csr(REG_KEEP_LIMIT, 1024);
         2: write_csr(REG_KEEP_LIMIT, 2047);
         default: write_csr(REG_KEEP_LIMIT, $urandom_range(1, 6));
      endcase
      write_csr(REG_LIMIT_EN, $urandom_range(3) != 0);
      pushes = board.clamp_dim(w) * board.clamp_dim(h);
      if (pushes > 150) pushes = 150;
      pushes += $urandom_range(3);
      if ($urandom_range(7) != 0) send_item(FUNC_CLEAR, 16'($urandom()));
      for (int i = 0; i < pushes; i++) begin
         if ($urandom_range(19) == 0) send_item(FUNC_FETCH, 16'($urandom()));
         if ($urandom_range(39) == 0) send_item(FUNC_RESERVED, 16'($urandom()));
         send_item(FUNC_PUSH, pick_score(thr));
      end
      fetches = board.kept + $urandom_range(1, 2);
      for (int i = 0; i < fetches; i++) send_item(FUNC_FETCH, 16'($urandom()));
   endtask

   initial begin
      logic [15:0] small_map [16];
      small_map = '{16'd0, 16'd500, 16'd65535, 16'd7,
                    16'd9, 16'd300, 16'd300, 16'd3,
                    16'd2, 16'd65535, 16'd100, 16'd1,
                    16'd65535, 16'd4, 16'd101, 16'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: 4x4 map, one pixel border, keep limit 3, three of four interior pixels survive
      write_csr(REG_MAP_WIDTH, 4);
      write_csr(REG_MAP_HEIGHT, 4);
      write_csr(REG_THRESHOLD, 100);
      write_csr(REG_BORDER, 1);
      write_csr(REG_KEEP_LIMIT, 3);
      write_csr(REG_LIMIT_EN, 1);
      send_item(FUNC_FETCH, 16'hFFFF);
      send_item(FUNC_CLEAR, 16'd0);
      foreach (small_map[i]) send_item(FUNC_PUSH, small_map[i]);
      send_item(FUNC_PUSH, 16'hFFFF);  // past the last row, ignored
      send_item(FUNC_RESERVED, 16'hFFFF);
      repeat (5) send_item(FUNC_FETCH, 16'd0);

      // the overflow run below adds about 1100 items
      for (int n = 0; items_sent < 260; n++) random_frame(n);

      // unlimited mode past storage capacity
      settle();
      set_mode(3);
      write_csr(REG_MAP_WIDTH, 33);
      write_csr(REG_MAP_HEIGHT, 33);
      write_csr(REG_THRESHOLD, 0);
      write_csr(REG_BORDER, 0);
      write_csr(REG_LIMIT_EN, 0);
      send_item(FUNC_CLEAR, 16'd0);
      repeat (33 * 33) send_item(FUNC_PUSH, 16'($urandom_range(1, 65535)));
      repeat (4) send_item(FUNC_FETCH, 16'd0);

      settle();
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/ktts_pkg.sv
rtl/ktts_ctrl.sv
rtl/ktts_dp.sv
rtl/keypoint_threshold_topk_select.sv
tb/testbench.sv
